FILE: src/button_press_classifier_macros.svh
// Assertion macros shared by the button press classifier RTL.
// Every macro assumes clk_i and rst_ni are visible where it is used.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// A property checked on every rising edge outside reset.
`define BPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A same-cycle implication checked on every rising edge outside reset.
`define BPC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A next-cycle implication checked on every rising edge outside reset.
`define BPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bpc_pkg.sv
// Package for the button press classifier: sizes, state codes and shared types.
// No dependencies; used by the interfaces, the per-button FSM and the top level.
package bpc_pkg;

  localparam int NumButtons = 4;
  localparam int CountBits  = 8;
  localparam int InputBits  = 4;
  localparam int OutButtons = 4;
  localparam int CfgW       = 8;
  localparam int CfgIdxW    = 1;
  localparam int StateW     = 3;
  localparam int CmpW       = (CountBits > CfgW) ? CountBits : CfgW;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Per-button state codes; also the reported encoding.
  localparam logic [StateW-1:0] StIdle     = 3'd0;
  localparam logic [StateW-1:0] StPressed  = 3'd1;
  localparam logic [StateW-1:0] StReleased = 3'd2;
  localparam logic [StateW-1:0] StShort    = 3'd3;
  localparam logic [StateW-1:0] StLong     = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegLongTicks  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegShortTicks = 1'd1;

  localparam logic [CfgW-1:0] LongTicksRst  = 8'd150;
  localparam logic [CfgW-1:0] ShortTicksRst = 8'd10;

  typedef struct packed {
    logic [CfgW-1:0] long_ticks;
    logic [CfgW-1:0] short_ticks;
  } thr_t;

  typedef struct packed {
    logic              hit;
    logic [StateW-1:0] state;
  } btn_stat_t;

  typedef struct packed {
    logic                             event_flag;
    logic [OutButtons-1:0][StateW-1:0] state;
  } res_t;

endpackage

FILE: src/bpc_if.sv
// Valid/ready channel interfaces for the button press classifier.
// Depends on bpc_pkg for field widths.
interface bpc_in_if;
  logic                            valid;
  logic                            ready;
  logic [bpc_pkg::InputBits-1:0]   switch_levels;

  modport source (output valid, output switch_levels, input ready);
  modport sink   (input valid, input switch_levels, output ready);
endinterface

interface bpc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         event_flag;
  logic [bpc_pkg::StateW-1:0]   button0_state;
  logic [bpc_pkg::StateW-1:0]   button1_state;
  logic [bpc_pkg::StateW-1:0]   button2_state;
  logic [bpc_pkg::StateW-1:0]   button3_state;

  modport source (output valid, output event_flag, output button0_state,
                  output button1_state, output button2_state, output button3_state,
                  input ready);
  modport sink   (input valid, input event_flag, input button0_state,
                  input button1_state, input button2_state, input button3_state,
                  output ready);
endinterface

FILE: src/bpc_button.sv
// One button's press state machine and saturating held-tick counter.
// Depends on bpc_pkg for state codes, widths and the threshold struct.
module bpc_button (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               down_i,
  input  bpc_pkg::thr_t      thr_i,
  output bpc_pkg::btn_stat_t stat_o
);

  logic [bpc_pkg::StateW-1:0]    state_q, state_d;
  logic [bpc_pkg::CountBits-1:0] held_q, held_d, held_inc;
  logic                          hit;

  assign held_inc = (held_q == bpc_pkg::CountMax) ? held_q
                                                  : held_q + bpc_pkg::CountBits'(1);

  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    hit     = 1'b0;
    unique case (state_q)
      bpc_pkg::StIdle: begin
        if (down_i) begin
          state_d = bpc_pkg::StPressed;
          held_d  = '0;
        end
      end
      bpc_pkg::StPressed: begin
        if (down_i) begin
          held_d = held_inc;
          if (bpc_pkg::CmpW'(held_inc) > bpc_pkg::CmpW'(thr_i.long_ticks)) begin
            state_d = bpc_pkg::StLong;
            hit     = 1'b1;
          end
        end else begin
          state_d = bpc_pkg::StReleased;
        end
      end
      bpc_pkg::StReleased: begin
        if (bpc_pkg::CmpW'(held_q) > bpc_pkg::CmpW'(thr_i.short_ticks)) begin
          state_d = bpc_pkg::StShort;
          hit     = 1'b1;
        end else begin
          state_d = bpc_pkg::StIdle;
        end
      end
      bpc_pkg::StShort: begin
        state_d = bpc_pkg::StIdle;
      end
      bpc_pkg::StLong: begin
        if (!down_i) begin
          state_d = bpc_pkg::StIdle;
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  // The result reports the state after this tick.
  assign stat_o.state = state_d;
  assign stat_o.hit   = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpc_pkg::StIdle;
      held_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      held_q  <= held_d;
    end
  end

endmodule

FILE: src/button_press_classifier.sv
// Top level of the button press classifier: channels, thresholds, output buffer.
// Depends on bpc_pkg, bpc_if.sv, bpc_button and button_press_classifier_macros.svh.
//
// Usage: each transfer on in_i is one scan tick carrying the active-low levels
// of four buttons in switch_levels. Each button runs a five-state machine
// (idle, pressed, released, short press, long press) with a saturating
// held-tick counter. Every tick produces exactly one transfer on out_o with the
// four button states after that tick and event_flag, which is set when any
// button entered short press or long press on that tick.
// The thresholds are written through cfg_we_i / cfg_idx_i / cfg_wdata_i:
// index 0 is the long press threshold, index 1 the short press threshold.
// Writes are expected only while no tick is in flight.
// Throughput is one tick per cycle while in_i.ready is high. The state machines
// update in the cycle of the input transfer, and the result is registered
// into the output register, or into the skid register while out_o is stalled.
// A two-entry output buffer (output register plus skid register) lets the block
// take one more tick while out_o is stalled; in_i.ready drops only when both
// entries are full. Reset clears all buttons to idle with zero counts, empties
// the output buffer and restores the thresholds to 150 and 10.
`include "button_press_classifier_macros.svh"

module button_press_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bpc_in_if.sink                        in_i,
  bpc_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::CfgW-1:0]      cfg_wdata_i
);

  bpc_pkg::thr_t      thr_q;
  bpc_pkg::btn_stat_t stat [bpc_pkg::NumButtons];
  bpc_pkg::res_t      res_new;
  bpc_pkg::res_t      out_q, out_d, skid_q, skid_d;
  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  logic               in_fire, out_fire;
  logic [bpc_pkg::NumButtons-1:0] hits;

  // Threshold registers. An index that names no register is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.long_ticks  <= bpc_pkg::LongTicksRst;
      thr_q.short_ticks <= bpc_pkg::ShortTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpc_pkg::RegLongTicks:  thr_q.long_ticks  <= cfg_wdata_i;
        bpc_pkg::RegShortTicks: thr_q.short_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The buffer has room as long as the skid entry is free.
  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  // One state machine per button; a button with no input bit reads as released.
  for (genvar b = 0; b < bpc_pkg::NumButtons; b++) begin : g_btn
    logic down;
    if (b < bpc_pkg::InputBits) begin : g_pin
      assign down = !in_i.switch_levels[b];
    end else begin : g_nopin
      assign down = 1'b0;
    end

    bpc_button u_button (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (in_fire),
      .down_i (down),
      .thr_i  (thr_q),
      .stat_o (stat[b])
    );

    assign hits[b] = stat[b].hit;
  end

  // Reported buttons that do not exist read as idle.
  for (genvar b = 0; b < bpc_pkg::OutButtons; b++) begin : g_rep
    if (b < bpc_pkg::NumButtons) begin : g_real
      assign res_new.state[b] = stat[b].state;
    end else begin : g_none
      assign res_new.state[b] = bpc_pkg::StIdle;
    end
  end
  assign res_new.event_flag = |hits;

  // Output buffer: the skid entry drains into the output register first.
  // A new result lands in the skid entry only while the output register holds.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res_new;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = res_new;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_flag    = out_q.event_flag;
  assign out_o.button0_state = out_q.state[0];
  assign out_o.button1_state = out_q.state[1];
  assign out_o.button2_state = out_q.state[2];
  assign out_o.button3_state = out_q.state[3];

  // The skid entry never holds a result while the output register is empty.
  `BPC_ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full while output empty")

  // An event can only be reported together with a short or long press state.
  `BPC_ASSERT_IMPL(a_event_has_press, out_valid_q && out_q.event_flag, (out_q.state[0] == bpc_pkg::StShort) || (out_q.state[0] == bpc_pkg::StLong) || (out_q.state[1] == bpc_pkg::StShort) || (out_q.state[1] == bpc_pkg::StLong) || (out_q.state[2] == bpc_pkg::StShort) || (out_q.state[2] == bpc_pkg::StLong) || (out_q.state[3] == bpc_pkg::StShort) || (out_q.state[3] == bpc_pkg::StLong), "event without press state")

  // A tick taken while the output is stalled must be parked in the skid entry.
  `BPC_ASSERT_NEXT(a_stall_parks, in_fire && out_valid_q && !out_o.ready, skid_valid_q, "stalled result was dropped")

endmodule
